/* hdl/arts_pkg.sv */
package arts_pkg;

  // Field and state widths.
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned FREQ_W     = 32;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned SUM_W      = RATE_W + 1;
  localparam int unsigned NOM_W      = 23;  // holds (2^32 - 1) / 1000 plus ten percent
  localparam int unsigned COARSE_W   = 10;  // nominal / 5000
  localparam int unsigned MEDIUM_W   = 7;   // nominal / 50000
  localparam int unsigned PCT_W      = 16;  // nominal / 100
  localparam int unsigned LIM_W      = 19;  // (nominal / 100) * 10
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 4;

  // Register reset values.
  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd100000000;
  localparam logic [TIME_W-1:0] END_RESET  = 64'hFFFF_FFFF_FFFF_FFFF;

  // Exact reciprocals: floor(x / d) == (x * M) >> S over the whole input range.
  localparam int unsigned        RECIP_MS_W      = 29;
  localparam logic [28:0]        RECIP_MS        = 29'd274877907;
  localparam int unsigned        RECIP_MS_SH     = 38;
  localparam int unsigned        RECIP_W         = 24;
  localparam logic [23:0]        RECIP_COARSE    = 24'd13743896;
  localparam int unsigned        RECIP_COARSE_SH = 36;
  localparam logic [23:0]        RECIP_MEDIUM    = 24'd10995117;
  localparam int unsigned        RECIP_MEDIUM_SH = 39;
  localparam logic [23:0]        RECIP_PCT       = 24'd10737419;
  localparam int unsigned        RECIP_PCT_SH    = 30;
  localparam logic [3:0]         LIMIT_MUL       = 4'd10;

  // Derived values for the reset frequency.
  localparam logic [NOM_W-1:0]    NOM_RESET    = 23'd100000;
  localparam logic [COARSE_W-1:0] COARSE_RESET = 10'd20;
  localparam logic [MEDIUM_W-1:0] MEDIUM_RESET = 7'd2;
  localparam logic [PCT_W-1:0]    PCT_RESET    = 16'd1000;
  localparam logic [NOM_W-1:0]    HI_RESET     = 23'd110000;
  localparam logic [NOM_W-1:0]    LO_RESET     = 23'd90000;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_RESET  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADJUST = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QRESET = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QSTOP  = 3'd4;

  // Rate adjust codes (two's complement, slower means a larger rate).
  localparam logic [CODE_W-1:0] ADJ_FINE_UP     = 3'd1;
  localparam logic [CODE_W-1:0] ADJ_MEDIUM_UP   = 3'd2;
  localparam logic [CODE_W-1:0] ADJ_COARSE_UP   = 3'd3;
  localparam logic [CODE_W-1:0] ADJ_COARSE_DOWN = 3'd5;
  localparam logic [CODE_W-1:0] ADJ_MEDIUM_DOWN = 3'd6;
  localparam logic [CODE_W-1:0] ADJ_FINE_DOWN   = 3'd7;

  // Register indexes, selected by paddr[3].
  localparam logic REG_FREQ = 1'b0;
  localparam logic REG_END  = 1'b1;

  typedef struct packed {
    logic [NOM_W-1:0]    nom;
    logic [COARSE_W-1:0] coarse;
    logic [MEDIUM_W-1:0] medium_step;
    logic [NOM_W-1:0]    hi;
    logic [NOM_W-1:0]    lo;
  } arts_rate_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETTLE0,
    S_SETTLE1,
    S_EXEC,
    S_DELTA,
    S_WRAP,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ACCUM,
    S_ADJ_ADD,
    S_ADJ_CLAMP,
    S_DONE
  } arts_state_t;

endpackage

/* hdl/arts_if.sv */
interface arts_in_if
  import arts_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [TIME_W-1:0]        counter_now;
  logic signed [CODE_W-1:0] adjust_code;

  modport source (output valid, output action, output counter_now, output adjust_code,
                  input ready);
  modport sink   (input valid, input action, input counter_now, input adjust_code,
                  output ready);
endinterface

interface arts_out_if
  import arts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] tpm_time;
  logic              flag;

  modport source (output valid, output tpm_time, output flag, input ready);
  modport sink   (input valid, input tpm_time, input flag, output ready);
endinterface

/* hdl/arts_mul.sv */
module arts_mul
  import arts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] mcand,
  input  logic [NOM_W-1:0]  mplier,
  output logic [TIME_W-1:0] prod,
  output logic              done
);

  // One multiplier bit per cycle, LSB first; the product wraps modulo 2^64.
  localparam int unsigned        CNT_W = $clog2(NOM_W);
  localparam logic [CNT_W-1:0]   LAST  = CNT_W'(NOM_W - 1);
  localparam int unsigned        LAT   = NOM_W + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] acc_r, acc_nxt;
  logic [TIME_W-1:0] a_r, a_nxt;
  logic [NOM_W-1:0]  b_r, b_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = {a_r[TIME_W-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[NOM_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      a_nxt    = mcand;
      b_nxt    = mplier;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

  a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |-> ##LAT done_r)
    else $error("multiplier did not finish in the expected number of cycles");

endmodule

/* hdl/arts_div.sv */
module arts_div
  import arts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic [TIME_W-1:0] quotient,
  output logic              done
);

  // Restoring division, one quotient bit per cycle, MSB first.
  localparam int unsigned      CNT_W = $clog2(TIME_W);
  localparam logic [CNT_W-1:0] LAST  = CNT_W'(TIME_W - 1);
  localparam int unsigned      LAT   = TIME_W + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [RATE_W-1:0] dvs_r, dvs_nxt;
  logic [RATE_W:0]   part;
  logic [RATE_W:0]   diff;
  logic              fits;

  assign part = {rem_r, quo_r[TIME_W-1]};
  assign diff = part - {1'b0, dvs_r};
  assign fits = (part >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      rem_nxt = fits ? diff[RATE_W-1:0] : part[RATE_W-1:0];
      quo_nxt = {quo_r[TIME_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |-> ##LAT done_r)
    else $error("divider did not finish in the expected number of cycles");

endmodule

/* hdl/arts_rate_const.sv */
module arts_rate_const
  import arts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FREQ_W-1:0] freq,
  output arts_rate_t        rate_lim
);

  localparam int unsigned P1_W = FREQ_W + RECIP_MS_W;
  localparam int unsigned P2_W = NOM_W + RECIP_W;

  logic [P1_W-1:0]     p_nom;
  logic [P2_W-1:0]     p_coarse;
  logic [P2_W-1:0]     p_medium;
  logic [P2_W-1:0]     p_pct;
  logic [LIM_W-1:0]    lim;

  logic [NOM_W-1:0]    nom_r, nom_nxt;
  logic [COARSE_W-1:0] coarse_r, coarse_nxt;
  logic [MEDIUM_W-1:0] medium_r, medium_nxt;
  logic [PCT_W-1:0]    pct_r, pct_nxt;
  logic [NOM_W-1:0]    nom_d_r, nom_d_nxt;
  logic [NOM_W-1:0]    hi_r, hi_nxt;
  logic [NOM_W-1:0]    lo_r, lo_nxt;

  // Stage one: nominal rate = freq / 1000.
  assign p_nom   = P1_W'(freq) * P1_W'(RECIP_MS);
  assign nom_nxt = p_nom[RECIP_MS_SH +: NOM_W];

  // Stage two: step sizes and one percent of nominal, all from the same nominal.
  assign p_coarse   = P2_W'(nom_r) * P2_W'(RECIP_COARSE);
  assign p_medium   = P2_W'(nom_r) * P2_W'(RECIP_MEDIUM);
  assign p_pct      = P2_W'(nom_r) * P2_W'(RECIP_PCT);
  assign coarse_nxt = p_coarse[RECIP_COARSE_SH +: COARSE_W];
  assign medium_nxt = p_medium[RECIP_MEDIUM_SH +: MEDIUM_W];
  assign pct_nxt    = p_pct[RECIP_PCT_SH +: PCT_W];
  assign nom_d_nxt  = nom_r;

  // Stage three: clamp window nominal +/- ten percent. The limit never exceeds
  // nominal, so the lower bound cannot wrap.
  assign lim    = LIM_W'(pct_r) * LIM_W'(LIMIT_MUL);
  assign hi_nxt = nom_d_r + NOM_W'(lim);
  assign lo_nxt = nom_d_r - NOM_W'(lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_r    <= NOM_RESET;
      coarse_r <= COARSE_RESET;
      medium_r <= MEDIUM_RESET;
      pct_r    <= PCT_RESET;
      nom_d_r  <= NOM_RESET;
      hi_r     <= HI_RESET;
      lo_r     <= LO_RESET;
    end else begin
      nom_r    <= nom_nxt;
      coarse_r <= coarse_nxt;
      medium_r <= medium_nxt;
      pct_r    <= pct_nxt;
      nom_d_r  <= nom_d_nxt;
      hi_r     <= hi_nxt;
      lo_r     <= lo_nxt;
    end
  end

  assign rate_lim.nom         = nom_r;
  assign rate_lim.coarse      = coarse_r;
  assign rate_lim.medium_step = medium_r;
  assign rate_lim.hi          = hi_r;
  assign rate_lim.lo          = lo_r;

endmodule

/* hdl/adjustable_rate_tick_timer_top.sv */
// Adjustable-rate tick timer, one request in flight: a time read that scales a delta runs
// the bit-serial multiplier and then the bit-serial divider; at a zero rate the divide is
// skipped. The next request is taken as soon as the previous one has moved into the
// result register. Reset (rst_n low, synchronous) restores both registers, clears the last
// sample, tick time, seen flags and result valid, and loads the nominal rate of the reset
// frequency.
module adjustable_rate_tick_timer_top
  import arts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  arts_in_if.sink               in_ch,
  arts_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Register 0 (frequency) lives at byte address 0 and
  // register 1 (counter end value) at byte address 8, so paddr[3] picks the
  // register. Writes complete in the APB access phase; the port never stalls.
  // ---------------------------------------------------------------------------
  logic              cfg_wr;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [TIME_W-1:0] end_r, end_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    freq_nxt = freq_r;
    end_nxt  = end_r;
    if (cfg_wr) begin
      if (cfg_paddr[3] == REG_FREQ) begin
        freq_nxt = cfg_pwdata[FREQ_W-1:0];
      end else begin
        end_nxt = cfg_pwdata;
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == REG_END) ? end_r : CFG_DATA_W'(freq_r);

  // ---------------------------------------------------------------------------
  // Derived rate values. The nominal rate, the coarse and medium steps and the
  // clamp window follow the frequency register through a short pipeline of
  // reciprocal multiplications. After a frequency write the nominal rate is
  // registered first, then the step sizes, then the clamp window; the two
  // settle states at the start of every request cover that gap.
  // ---------------------------------------------------------------------------
  arts_rate_t rate_lim;

  arts_rate_const u_rate_const (
    .clk      (clk),
    .rst_n    (rst_n),
    .freq     (freq_r),
    .rate_lim (rate_lim)
  );

  // ---------------------------------------------------------------------------
  // Timer state and request capture.
  // ---------------------------------------------------------------------------
  arts_state_t       state_r, state_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic              rst_seen_r, rst_seen_nxt;
  logic              stop_seen_r, stop_seen_nxt;
  logic              flag_r, flag_nxt;
  logic [TIME_W-1:0] delta_r, delta_nxt;
  logic              wrap_r, wrap_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  // Result register: a finished result waits here while the next request is
  // already being taken in.
  logic              out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;
  logic              out_flag_r, out_flag_nxt;

  // Control from the state decoder.
  logic              in_ready;
  logic              mul_start;
  logic              div_start;
  logic              out_load;

  // Serial arithmetic units.
  logic [TIME_W-1:0] mul_prod;
  logic              mul_done;
  logic [TIME_W-1:0] div_quo;
  logic              div_done;

  // Rate adjust helpers.
  logic [COARSE_W-1:0] step;
  logic                slower;
  logic [SUM_W-1:0]    clamp_hi;
  logic [SUM_W-1:0]    clamp_lo;

  // The product is the delta times the nominal rate, wrapped to 64 bits, and
  // is then divided by the current rate.
  arts_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (delta_r),
    .mplier (rate_lim.nom),
    .prod   (mul_prod),
    .done   (mul_done)
  );

  arts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (rate_r),
    .quotient (div_quo),
    .done     (div_done)
  );

  // ---------------------------------------------------------------------------
  // Next-state logic.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_SETTLE0;
        end
      end
      S_SETTLE0: state_nxt = S_SETTLE1;
      S_SETTLE1: state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (act_r)
          // A read with no previous sample only starts the timer.
          ACT_READ:   state_nxt = (last_r == '0) ? S_DONE : S_DELTA;
          ACT_ADJUST: state_nxt = S_ADJ_ADD;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_DELTA:   state_nxt = S_WRAP;
      S_WRAP:    state_nxt = S_MUL_GO;
      S_MUL_GO:  state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: begin
        // A zero rate scales every delta to zero, so the divide is skipped.
        if (mul_done) begin
          state_nxt = (rate_r != '0) ? S_DIV_GO : S_DONE;
        end
      end
      S_DIV_GO:  state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM:     state_nxt = S_DONE;
      S_ADJ_ADD:   state_nxt = S_ADJ_CLAMP;
      S_ADJ_CLAMP: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State decoder outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    mul_start = (state_r == S_MUL_GO);
    div_start = (state_r == S_DIV_GO);
    out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  end

  assign in_ch.ready = in_ready;

  // ---------------------------------------------------------------------------
  // Rate step decode. Codes 0 and 4 give no step; a faster request with no
  // step leaves the rate alone, and the clamp is still applied.
  // ---------------------------------------------------------------------------
  always_comb begin
    step   = '0;
    slower = 1'b0;
    unique case (code_r)
      ADJ_FINE_UP:     step = COARSE_W'(1);
      ADJ_MEDIUM_UP:   step = COARSE_W'(rate_lim.medium_step);
      ADJ_COARSE_UP:   step = rate_lim.coarse;
      ADJ_COARSE_DOWN: begin
        step   = rate_lim.coarse;
        slower = 1'b1;
      end
      ADJ_MEDIUM_DOWN: begin
        step   = COARSE_W'(rate_lim.medium_step);
        slower = 1'b1;
      end
      ADJ_FINE_DOWN: begin
        step   = COARSE_W'(1);
        slower = 1'b1;
      end
      default: begin
        step   = '0;
        slower = 1'b0;
      end
    endcase
  end

  // Upper bound first, then lower bound, matching the order of the clamp.
  assign clamp_hi = (sum_r > SUM_W'(rate_lim.hi)) ? SUM_W'(rate_lim.hi) : sum_r;
  assign clamp_lo = (clamp_hi < SUM_W'(rate_lim.lo)) ? SUM_W'(rate_lim.lo) : clamp_hi;

  // ---------------------------------------------------------------------------
  // Datapath.
  // ---------------------------------------------------------------------------
  always_comb begin
    act_nxt       = act_r;
    now_nxt       = now_r;
    code_nxt      = code_r;
    last_nxt      = last_r;
    time_nxt      = time_r;
    rate_nxt      = rate_r;
    rst_seen_nxt  = rst_seen_r;
    stop_seen_nxt = stop_seen_r;
    flag_nxt      = flag_r;
    delta_nxt     = delta_r;
    wrap_nxt      = wrap_r;
    sum_nxt       = sum_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt  = in_ch.action;
          now_nxt  = in_ch.counter_now;
          code_nxt = in_ch.adjust_code;
          flag_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        unique case (act_r)
          ACT_RESET: begin
            last_nxt      = now_r;
            time_nxt      = now_r;
            rate_nxt      = RATE_W'(rate_lim.nom);
            rst_seen_nxt  = 1'b1;
            stop_seen_nxt = 1'b1;
          end
          ACT_READ: begin
            if (last_r == '0) begin
              last_nxt = now_r;
              time_nxt = now_r;
            end
          end
          ACT_QRESET: begin
            flag_nxt     = rst_seen_r;
            rst_seen_nxt = 1'b0;
          end
          ACT_QSTOP: begin
            flag_nxt      = stop_seen_r;
            stop_seen_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_DELTA: begin
        // A sample below the last one means the counter wrapped: the distance
        // is (end - last) + now, the second add happening in the next cycle.
        if (now_r > last_r) begin
          delta_nxt = now_r - last_r;
          wrap_nxt  = 1'b0;
        end else if (now_r == last_r) begin
          delta_nxt = '0;
          wrap_nxt  = 1'b0;
        end else begin
          delta_nxt = end_r - last_r;
          wrap_nxt  = 1'b1;
        end
        last_nxt = now_r;
      end
      S_WRAP: begin
        if (wrap_r) begin
          delta_nxt = delta_r + now_r;
        end
      end
      S_ACCUM: begin
        time_nxt = time_r + div_quo;
      end
      S_ADJ_ADD: begin
        // A faster step larger than the rate bottoms out at zero.
        if (slower) begin
          sum_nxt = {1'b0, rate_r} + SUM_W'(step);
        end else if (rate_r > RATE_W'(step)) begin
          sum_nxt = {1'b0, rate_r - RATE_W'(step)};
        end else begin
          sum_nxt = '0;
        end
      end
      S_ADJ_CLAMP: begin
        rate_nxt = clamp_lo[RATE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_time_nxt  = out_time_r;
    out_flag_nxt  = out_flag_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_time_nxt  = time_r;
      out_flag_nxt  = flag_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tpm_time = out_time_r;
  assign out_ch.flag     = out_flag_r;

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= FREQ_RESET;
      end_r       <= END_RESET;
      state_r     <= S_IDLE;
      last_r      <= '0;
      time_r      <= '0;
      rate_r      <= RATE_W'(NOM_RESET);
      rst_seen_r  <= 1'b0;
      stop_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      freq_r      <= freq_nxt;
      end_r       <= end_nxt;
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      time_r      <= time_nxt;
      rate_r      <= rate_nxt;
      rst_seen_r  <= rst_seen_nxt;
      stop_seen_r <= stop_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    now_r      <= now_nxt;
    code_r     <= code_nxt;
    flag_r     <= flag_nxt;
    delta_r    <= delta_nxt;
    wrap_r     <= wrap_nxt;
    sum_r      <= sum_nxt;
    out_time_r <= out_time_nxt;
    out_flag_r <= out_flag_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_rate_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADJ_CLAMP) |=>
      (rate_r >= RATE_W'($past(rate_lim.lo)) && rate_r <= RATE_W'($past(rate_lim.hi))))
    else $error("adjusted rate left the clamp window");

  a_flag_only_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && flag_r) |-> (act_r == ACT_QRESET || act_r == ACT_QSTOP))
    else $error("flag set for a request that is not a flag query");

  a_time_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && act_r != ACT_READ && act_r != ACT_RESET) |=> $stable(time_r))
    else $error("tick time changed during a request that does not touch it");

endmodule
